// ----- rtl/mexp_pkg.sv -----
// shared types for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_MULR   = 5'b00100,
      ST_SQR    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      OP_REDUCE = 2'd0,
      OP_MULR   = 2'd1,
      OP_SQR    = 2'd2
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      op_type op;
      logic   emit;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic in_exp_zero;
      logic exp_lsb;
      logic exp_upper_zero;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/mexp_ctrl.sv -----
// sequencing state machine for square-and-multiply
`timescale 1ns / 1ps

module mexp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd
);
   import mexp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.op     = OP_REDUCE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.in_exp_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.start = 1'b1;
                  cmd.op    = OP_REDUCE;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE, ST_SQR: begin
            if (!status.busy) begin
               cmd.start = 1'b1;
               if (status.exp_lsb) begin
                  cmd.op   = OP_MULR;
                  state_in = ST_MULR;
               end else begin
                  cmd.op   = OP_SQR;
                  state_in = ST_SQR;
               end
            end
         end
         ST_MULR: begin
            if (!status.busy) begin
               if (status.exp_upper_zero) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.start = 1'b1;
                  cmd.op    = OP_SQR;
                  state_in  = ST_SQR;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/mexp_dp.sv -----
// operand registers, shift-add-reduce unit and result register
`timescale 1ns / 1ps

module mexp_dp #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mexp_pkg::cmd_type        cmd,
   output mexp_pkg::status_type     status,
   input  logic [OPERAND_WIDTH-1:0] req_base,
   input  logic [OPERAND_WIDTH-1:0] req_exp,
   input  logic [OPERAND_WIDTH-1:0] modulus,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [OPERAND_WIDTH-1:0] rsp_data
);
   import mexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = $clog2(OPERAND_WIDTH);

   logic [W-1:0]     base_ff, base_in;
   logic [W-1:0]     exp_ff, exp_in;
   logic [W-1:0]     res_ff, res_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     mplr_ff, mplr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   op_type           op_ff, op_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]     rsp_data_ff, rsp_data_in;

   logic [W-1:0]     mod_eff;
   logic [W-1:0]     addend;
   logic [W+1:0]     sum;
   logic [W+1:0]     mod_x1;
   logic [W+1:0]     mod_x2;
   logic [W-1:0]     acc_step;

   // a zero modulus behaves as one
   assign mod_eff = (modulus == '0) ? W'(1) : modulus;

   // one multiplier bit per cycle: acc = 2*acc + bit*addend, reduced
   always_comb begin
      addend = '0;
      if (mplr_ff[W-1]) begin
         case (op_ff)
            OP_REDUCE: addend = W'(1);
            OP_MULR:   addend = res_ff;
            OP_SQR:    addend = base_ff;
            default:   addend = '0;
         endcase
      end
      sum    = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
      mod_x1 = {2'b00, mod_eff};
      mod_x2 = {1'b0, mod_eff, 1'b0};
      if (sum >= mod_x2) begin
         acc_step = W'(sum - mod_x2);
      end else if (sum >= mod_x1) begin
         acc_step = W'(sum - mod_x1);
      end else begin
         acc_step = W'(sum);
      end
   end

   always_comb begin
      base_in      = base_ff;
      exp_in       = exp_ff;
      res_in       = res_ff;
      acc_in       = acc_ff;
      mplr_in      = mplr_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         base_in = req_base;
         exp_in  = req_exp;
         res_in  = W'(1);
      end

      if (busy_ff) begin
         acc_in  = acc_step;
         mplr_in = {mplr_ff[W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            case (op_ff)
               OP_REDUCE: base_in = acc_step;
               OP_MULR:   res_in  = acc_step;
               OP_SQR: begin
                  base_in = acc_step;
                  exp_in  = {1'b0, exp_ff[W-1:1]};
               end
               default: ;
            endcase
         end
      end

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(W - 1);
         acc_in  = '0;
         op_in   = cmd.op;
         mplr_in = cmd.load ? req_base : base_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
      acc_ff      <= acc_in;
      mplr_ff     <= mplr_in;
      cnt_ff      <= cnt_in;
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.busy           = busy_ff;
   assign status.in_exp_zero    = (req_exp == '0);
   assign status.exp_lsb        = exp_ff[0];
   assign status.exp_upper_zero = (exp_ff[W-1:1] == '0);
   assign status.out_free       = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/modular_exponentiation_top.sv -----
// top level of the modular exponentiation block
//
//  channel  direction  handshake          payload
//  req      in         tvalid / tready    base_value, exponent
//  rsp      out        tvalid / tready    power_result
//  csr      in         apb write / read   modulus (register 0)
//
// zero exponent: the result 1 is returned without running the multiply unit
// otherwise the base is reduced first; each set exponent bit then multiplies
// it into the result, and the base is squared until no set bit is left above
// all steps run on the shared shift-add-reduce unit, one bit a cycle
// synchronous active-high reset, modulus resets to 1
// a waiting result is held in the output register while the next item is taken
`timescale 1ns / 1ps

module modular_exponentiation_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   // base_value, exponent
   input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]                 req_tdata,
   output logic                                                 rsp_tvalid,
   input  logic                                                 rsp_tready,
   // power_result
   output logic [((OPERAND_WIDTH+7)/8)*8-1:0]                   rsp_tdata,
   input  logic                                                 csr_psel,
   input  logic                                                 csr_penable,
   input  logic                                                 csr_pwrite,
   input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0]            csr_paddr,
   input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0]          csr_pwdata,
   output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0]          csr_prdata,
   output logic                                                 csr_pready
);
   import mexp_pkg::*;

   localparam int W      = OPERAND_WIDTH;
   localparam int RSP_W  = ((OPERAND_WIDTH + 7) / 8) * 8;
   localparam int CSR_W  = (OPERAND_WIDTH > 32) ? 64 : 32;
   localparam int ADDR_W = (OPERAND_WIDTH > 32) ? 4 : 3;
   localparam logic REG_MODULUS = 1'b0;

   logic [W-1:0] modulus_ff, modulus_in;
   logic         csr_write;
   logic [W-1:0] rsp_data;
   cmd_type      cmd;
   status_type   status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[ADDR_W-1] == REG_MODULUS);

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write) begin
         modulus_in = csr_pwdata[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= W'(1);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign csr_prdata = (csr_paddr[ADDR_W-1] == REG_MODULUS) ? CSR_W'(modulus_ff) : '0;

   mexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mexp_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_base   (req_tdata[W-1:0]),
      .req_exp    (req_tdata[2*W-1:W]),
      .modulus    (modulus_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = RSP_W'(rsp_data);

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("transaction accepted while another is in progress");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.busy || cmd.load)
      else $error("multiply started while the unit is running");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("result not presented after emit");
`endif

endmodule
